// File: sv/dtti_pkg.sv
// Shared types, codes and constants for the decimal text to integer converter.
`default_nettype none

package dtti_pkg;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] text_byte;
	} in_word_t;

	typedef struct packed {
		logic signed [63:0] value;
		logic [2:0]         status;
	} out_word_t;

	localparam logic [1:0] OP_CHAR    = 2'd0;
	localparam logic [1:0] OP_END     = 2'd1;
	localparam logic [1:0] OP_MISSING = 2'd2;
	localparam logic [1:0] OP_UNUSED  = 2'd3;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_MISSING = 3'd1;
	localparam logic [2:0] ST_EMPTY   = 3'd2;
	localparam logic [2:0] ST_OVER    = 3'd3;
	localparam logic [2:0] ST_UNDER   = 3'd4;
	localparam logic [2:0] ST_INVALID = 3'd5;

	localparam logic [1:0] PH_LEAD   = 2'd0;
	localparam logic [1:0] PH_SIGN   = 2'd1;
	localparam logic [1:0] PH_DIGITS = 2'd2;
	localparam logic [1:0] PH_BAD    = 2'd3;

	localparam logic [63:0] CAP63       = 64'h8000_0000_0000_0000;
	localparam logic [63:0] TENTH_LIMIT = 64'd922337203685477580;
	localparam logic [63:0] MAX64_POS   = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] MAX32_POS   = 64'h0000_0000_7FFF_FFFF;
	localparam logic [63:0] MAX32_NEG   = 64'h0000_0000_8000_0000;

	localparam logic [7:0] CHR_ZERO  = 8'd48;
	localparam logic [7:0] CHR_NINE  = 8'd57;
	localparam logic [7:0] CHR_TAB   = 8'd9;
	localparam logic [7:0] CHR_CR    = 8'd13;
	localparam logic [7:0] CHR_SPACE = 8'd32;
	localparam logic [7:0] CHR_PLUS  = 8'd43;
	localparam logic [7:0] CHR_MINUS = 8'd45;

endpackage

`default_nettype wire

// File: sv/dtti_field.sv
// Field state and per-word parsing: digit accumulation, sign, and the final range check.
`default_nettype none

module dtti_field (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 fire,
	input  wire dtti_pkg::in_word_t   item,
	input  wire logic                 wide_mode,
	output logic                      has_result,
	output dtti_pkg::out_word_t       result
);

	logic [1:0]  phase_q, phase_d;
	logic        negative_q, negative_d;
	logic [63:0] magnitude_q, magnitude_d;
	logic        saturated_q, saturated_d;

	logic        is_digit;
	logic        is_space;
	logic        is_sign;
	logic [63:0] mag_next;
	logic [63:0] limit;

	assign is_digit = (item.text_byte >= dtti_pkg::CHR_ZERO) &&
		(item.text_byte <= dtti_pkg::CHR_NINE);
	assign is_space = ((item.text_byte >= dtti_pkg::CHR_TAB) &&
		(item.text_byte <= dtti_pkg::CHR_CR)) || (item.text_byte == dtti_pkg::CHR_SPACE);
	assign is_sign = (item.text_byte == dtti_pkg::CHR_PLUS) ||
		(item.text_byte == dtti_pkg::CHR_MINUS);

	// The magnitude is at most the tenth limit here, so ten times it plus a digit fits 64 bits.
	assign mag_next = (magnitude_q << 3) + (magnitude_q << 1) + {60'd0, item.text_byte[3:0]};

	always_comb begin
		phase_d     = phase_q;
		negative_d  = negative_q;
		magnitude_d = magnitude_q;
		saturated_d = saturated_q;
		has_result  = 1'b0;
		result      = '{value: 64'sd0, status: dtti_pkg::ST_OK};
		limit       = '0;
		unique case (item.opcode)
			dtti_pkg::OP_CHAR: begin
				if (phase_q != dtti_pkg::PH_BAD) begin
					if (is_digit) begin
						phase_d = dtti_pkg::PH_DIGITS;
						if (!saturated_q) begin
							if (magnitude_q > dtti_pkg::TENTH_LIMIT) begin
								saturated_d = 1'b1;
								magnitude_d = dtti_pkg::CAP63;
							end else if (mag_next > dtti_pkg::CAP63) begin
								saturated_d = 1'b1;
								magnitude_d = dtti_pkg::CAP63;
							end else begin
								magnitude_d = mag_next;
							end
						end
					end else if (phase_q == dtti_pkg::PH_LEAD && is_space) begin
						phase_d = phase_q;
					end else if (phase_q == dtti_pkg::PH_LEAD && is_sign) begin
						negative_d = (item.text_byte == dtti_pkg::CHR_MINUS);
						phase_d    = dtti_pkg::PH_SIGN;
					end else begin
						phase_d = dtti_pkg::PH_BAD;
					end
				end
			end
			dtti_pkg::OP_END: begin
				has_result = 1'b1;
				if (phase_q == dtti_pkg::PH_LEAD) begin
					result.status = dtti_pkg::ST_EMPTY;
				end else if (phase_q != dtti_pkg::PH_DIGITS) begin
					result.status = dtti_pkg::ST_INVALID;
				end else if (negative_q) begin
					limit = wide_mode ? dtti_pkg::CAP63 : dtti_pkg::MAX32_NEG;
					if (saturated_q || magnitude_q > limit) begin
						result.status = dtti_pkg::ST_UNDER;
					end else begin
						result.value = $signed(64'd0 - magnitude_q);
					end
				end else begin
					limit = wide_mode ? dtti_pkg::MAX64_POS : dtti_pkg::MAX32_POS;
					if (saturated_q || magnitude_q > limit) begin
						result.status = dtti_pkg::ST_OVER;
					end else begin
						result.value = $signed(magnitude_q);
					end
				end
				phase_d     = dtti_pkg::PH_LEAD;
				negative_d  = 1'b0;
				magnitude_d = '0;
				saturated_d = 1'b0;
			end
			dtti_pkg::OP_MISSING: begin
				has_result    = 1'b1;
				result.status = dtti_pkg::ST_MISSING;
				phase_d       = dtti_pkg::PH_LEAD;
				negative_d    = 1'b0;
				magnitude_d   = '0;
				saturated_d   = 1'b0;
			end
			default: begin
				has_result = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= dtti_pkg::PH_LEAD;
			negative_q  <= 1'b0;
			magnitude_q <= '0;
			saturated_q <= 1'b0;
		end else if (fire) begin
			phase_q     <= phase_d;
			negative_q  <= negative_d;
			magnitude_q <= magnitude_d;
			saturated_q <= saturated_d;
		end
	end

endmodule

`default_nettype wire

// File: sv/decimal_text_to_integer_top.sv
// Top level of the decimal text to integer converter: input register, field parser, result register.
// The block reads one text field one byte word at a time by base-10 strtol rules and returns one
// result word (value and status) for each end-of-field or missing-field word. It takes one input
// word every clock cycle unless a result word is stalled behind a full result register that is not
// taken; a result passes through one input register and one result register, with the parsing
// logic between them. Input words keep flowing while a result waits to be taken, until that
// result and a following result word would collide. The mode register is written through the
// configuration channel, which is always ready, and should be written only while the block is idle.
`default_nettype none

module decimal_text_to_integer_top (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic                 cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire dtti_pkg::in_word_t   in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output dtti_pkg::out_word_t       out_data
);

	dtti_pkg::in_word_t  item_s1;
	logic                valid_s1;
	logic                wide_mode_q;
	dtti_pkg::out_word_t out_q;
	logic                out_valid_q;
	logic                has_result;
	dtti_pkg::out_word_t result;
	logic                fire;

	assign cfg_ready = 1'b1;
	assign fire      = valid_s1 && (!has_result || !out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || fire;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	dtti_field u_field (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.item       (item_s1),
		.wide_mode  (wide_mode_q),
		.has_result (has_result),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_mode_q <= 1'b0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				wide_mode_q <= cfg_data;
			end
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire && has_result) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
		if (fire && has_result) begin
			out_q <= result;
		end
	end

endmodule

`default_nettype wire
